[rtl/clock_buffer_frame_manager_defines.svh]
// Assertion macros used by the checker file of the frame manager.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef CLOCK_BUFFER_FRAME_MANAGER_DEFINES_SVH
`define CLOCK_BUFFER_FRAME_MANAGER_DEFINES_SVH

// Same-cycle implication, off during reset
`define CBFM_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbfm: check failed");

// Next-cycle implication, off during reset
`define CBFM_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbfm: check failed");

`endif

[rtl/cbfm_pkg.sv]
// Shared types for the clock frame manager: word layouts, command codes,
// controller states and the controller/datapath handshake structs.
package cbfm_pkg;

    // Command codes carried in the command field
    typedef enum logic [3:0] {
        CMD_FIND   = 4'd0,
        CMD_VICTIM = 4'd1,
        CMD_READ   = 4'd2,
        CMD_PIN    = 4'd3,
        CMD_UNPIN  = 4'd4,
        CMD_DIRTY  = 4'd5,
        CMD_WRITE  = 4'd6,
        CMD_LOADED = 4'd7,
        CMD_SAVED  = 4'd8,
        CMD_SET_ID = 4'd9
    } cmd_code_t;

    // Request word
    typedef struct packed {
        logic [3:0]  command;
        logic [5:0]  frame;
        logic [15:0] page;
    } req_t;

    // Response word
    typedef struct packed {
        logic [5:0]  frame_out;
        logic        found;
        logic        none_free;
        logic [15:0] page_out;
        logic        dirty_out;
        logic        pinned_out;
        logic [31:0] io_total;
    } rsp_t;

    // Controller states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_FIND_RD,
        ST_FIND_CHK,
        ST_VIC_RD,
        ST_VIC_CHK,
        ST_MOD_RD,
        ST_MOD_WR,
        ST_REP_RD,
        ST_REP_CAP,
        ST_DONE
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic clear_wr;      // write reset word at scan index, advance index
        logic accept;        // latch request word
        logic find_start;    // scan index to zero
        logic vic_start;     // scan index to clock hand
        logic rd_frame;      // read at request frame instead of scan index
        logic idx_inc;       // advance scan index with wrap
        logic find_hit;      // report scan index as found frame
        logic vic_take;      // report scan index as victim, move hand past it
        logic vic_clear_ref; // write back scanned frame with reference cleared
        logic none_free_set; // flag all frames pinned
        logic mod_wr;        // apply command to request frame
        logic rep_cap;       // take report fields from read data
        logic rep_zero;      // report fields of a frame that does not exist
        logic out_load;      // move result into the output register
    } ctl_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [3:0] cmd;
        logic       frame_ok;
        logic       all_pinned;
        logic       idx_last;
        logic       match;
        logic       rd_pin;
        logic       rd_ref;
        logic       out_free;
    } sts_t;

endpackage

[rtl/clock_buffer_frame_manager.sv]
// Top level of the clock-replacement frame manager.
// Depends on cbfm_pkg, cbfm_ctrl, cbfm_dpath and cbfm_ram.
//
// Usage:
//   Requests arrive on req (command, frame, page) with req_valid/req_stall;
//   one response word per request leaves on rsp with rsp_valid/rsp_stall.
//   A word moves at a rising edge with valid high and stall low.
//   One command is worked at a time. The frame table sits in one RAM with a
//   registered read port. Each frame visited takes a read state, then a
//   check or write state. The frames visited are:
//     read, pin, unpin, dirty, write, loaded, saved, set id: request frame
//     find: from frame zero to a page match; on a miss, the request frame
//     victim: from the clock hand, up to twice round the table
//   The next request is taken the cycle after the result enters the output
//   register, so a waiting response does not hold off the next command.
//   After reset a clearing pass writes each frame's page id to its own
//   index; req_stall stays high during it.
//   While rsp_stall is high the response holds, and a finished second result
//   waits inside until the output register frees.
module clock_buffer_frame_manager #(
    parameter int FRAMES    = 64,
    parameter int PAGE_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  cbfm_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output cbfm_pkg::rsp_t rsp
);

    cbfm_pkg::ctl_t ctl;
    cbfm_pkg::sts_t sts;

    cbfm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .ctl       (ctl)
    );

    cbfm_dpath #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_stall (rsp_stall),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .ctl       (ctl),
        .sts       (sts)
    );

endmodule

[rtl/cbfm_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module cbfm_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/cbfm_ctrl.sv]
// Controller of the frame manager: sequences the clearing pass, the frame
// scans and the read-modify-write of one frame. Depends on cbfm_pkg.
module cbfm_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  cbfm_pkg::sts_t sts,
    output cbfm_pkg::ctl_t ctl
);

    cbfm_pkg::state_t state_reg;
    cbfm_pkg::state_t state_next;
    logic             is_find;
    logic             is_victim;

    assign is_find   = (sts.cmd == cbfm_pkg::CMD_FIND);
    assign is_victim = (sts.cmd == cbfm_pkg::CMD_VICTIM);

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cbfm_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cbfm_pkg::ST_CLEAR:
            begin
                if (sts.idx_last)
                begin
                    state_next = cbfm_pkg::ST_IDLE;
                end
            end
            cbfm_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = cbfm_pkg::ST_START;
                end
            end
            cbfm_pkg::ST_START:
            begin
                if (is_find)
                begin
                    state_next = cbfm_pkg::ST_FIND_RD;
                end
                else if (is_victim && !sts.all_pinned)
                begin
                    state_next = cbfm_pkg::ST_VIC_RD;
                end
                else if (is_victim)
                begin
                    state_next = sts.frame_ok ? cbfm_pkg::ST_REP_RD : cbfm_pkg::ST_DONE;
                end
                else
                begin
                    state_next = sts.frame_ok ? cbfm_pkg::ST_MOD_RD : cbfm_pkg::ST_DONE;
                end
            end
            cbfm_pkg::ST_FIND_RD:
            begin
                state_next = cbfm_pkg::ST_FIND_CHK;
            end
            cbfm_pkg::ST_FIND_CHK:
            begin
                if (sts.match)
                begin
                    state_next = cbfm_pkg::ST_DONE;
                end
                else if (sts.idx_last)
                begin
                    state_next = sts.frame_ok ? cbfm_pkg::ST_REP_RD : cbfm_pkg::ST_DONE;
                end
                else
                begin
                    state_next = cbfm_pkg::ST_FIND_RD;
                end
            end
            cbfm_pkg::ST_VIC_RD:
            begin
                state_next = cbfm_pkg::ST_VIC_CHK;
            end
            cbfm_pkg::ST_VIC_CHK:
            begin
                if (!sts.rd_pin && !sts.rd_ref)
                begin
                    state_next = cbfm_pkg::ST_DONE;
                end
                else
                begin
                    state_next = cbfm_pkg::ST_VIC_RD;
                end
            end
            cbfm_pkg::ST_MOD_RD:
            begin
                state_next = cbfm_pkg::ST_MOD_WR;
            end
            cbfm_pkg::ST_MOD_WR:
            begin
                state_next = cbfm_pkg::ST_DONE;
            end
            cbfm_pkg::ST_REP_RD:
            begin
                state_next = cbfm_pkg::ST_REP_CAP;
            end
            cbfm_pkg::ST_REP_CAP:
            begin
                state_next = cbfm_pkg::ST_DONE;
            end
            cbfm_pkg::ST_DONE:
            begin
                if (sts.out_free)
                begin
                    state_next = cbfm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cbfm_pkg::ST_CLEAR;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        ctl       = '0;
        req_stall = 1'b1;
        unique case (state_reg)
            cbfm_pkg::ST_CLEAR:
            begin
                ctl.clear_wr = 1'b1;
            end
            cbfm_pkg::ST_IDLE:
            begin
                req_stall  = 1'b0;
                ctl.accept = req_valid;
            end
            cbfm_pkg::ST_START:
            begin
                ctl.find_start    = is_find;
                ctl.vic_start     = is_victim && !sts.all_pinned;
                ctl.none_free_set = is_victim && sts.all_pinned;
                ctl.rep_zero      = !is_find && !(is_victim && !sts.all_pinned)
                                    && !sts.frame_ok;
            end
            cbfm_pkg::ST_FIND_CHK:
            begin
                ctl.find_hit = sts.match;
                ctl.idx_inc  = !sts.match;
                ctl.rep_zero = !sts.match && sts.idx_last && !sts.frame_ok;
            end
            cbfm_pkg::ST_VIC_CHK:
            begin
                ctl.vic_take      = !sts.rd_pin && !sts.rd_ref;
                ctl.vic_clear_ref = !sts.rd_pin && sts.rd_ref;
                ctl.idx_inc       = sts.rd_pin || sts.rd_ref;
            end
            cbfm_pkg::ST_MOD_RD:
            begin
                ctl.rd_frame = 1'b1;
            end
            cbfm_pkg::ST_MOD_WR:
            begin
                ctl.mod_wr = 1'b1;
            end
            cbfm_pkg::ST_REP_RD:
            begin
                ctl.rd_frame = 1'b1;
            end
            cbfm_pkg::ST_REP_CAP:
            begin
                ctl.rep_cap = 1'b1;
            end
            cbfm_pkg::ST_DONE:
            begin
                ctl.out_load = sts.out_free;
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

endmodule

[rtl/cbfm_dpath.sv]
// Datapath of the frame manager: frame table RAM, scan index, clock hand,
// I/O counter, pinned count, result and output registers.
// Depends on cbfm_pkg and cbfm_ram.
module cbfm_dpath #(
    parameter int FRAMES    = 64,
    parameter int PAGE_BITS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  cbfm_pkg::req_t req,
    input  logic           rsp_stall,
    output logic           rsp_valid,
    output cbfm_pkg::rsp_t rsp,
    input  cbfm_pkg::ctl_t ctl,
    output cbfm_pkg::sts_t sts
);

    localparam int FW        = $clog2(FRAMES);
    localparam int PCW       = $clog2(FRAMES + 1);
    localparam int WW        = PAGE_BITS + 3;
    localparam int DIRTY_BIT = PAGE_BITS;
    localparam int PIN_BIT   = PAGE_BITS + 1;
    localparam int REF_BIT   = PAGE_BITS + 2;

    // Request latch
    logic [3:0]           cmd_reg;
    logic [5:0]           frame_reg;
    logic [PAGE_BITS-1:0] page_reg;
    // Scan and persistent state
    logic [FW-1:0]        idx_reg, idx_next;
    logic [FW-1:0]        hand_reg, hand_next;
    logic [31:0]          io_reg, io_next;
    logic [PCW-1:0]       pin_cnt_reg, pin_cnt_next;
    // Result in progress
    logic [5:0]           res_frame_reg, res_frame_next;
    logic                 res_found_reg, res_found_next;
    logic                 res_none_reg, res_none_next;
    logic [PAGE_BITS-1:0] res_page_reg, res_page_next;
    logic                 res_dirty_reg, res_dirty_next;
    logic                 res_pin_reg, res_pin_next;
    // Output register
    cbfm_pkg::rsp_t       rsp_reg, rsp_next;
    logic                 rsp_valid_reg, rsp_valid_next;

    logic [FW-1:0]        idx_wrap;
    logic [FW-1:0]        frame_idx;
    logic                 frame_ok;
    logic                 ram_we;
    logic [FW-1:0]        ram_waddr;
    logic [WW-1:0]        ram_wdata;
    logic [FW-1:0]        ram_raddr;
    logic [WW-1:0]        ram_rdata;
    logic [WW-1:0]        mod_word;
    logic [WW-1:0]        clear_word;
    logic                 io_bump;

    assign idx_wrap   = (idx_reg == FW'(FRAMES - 1)) ? '0 : idx_reg + 1'b1;
    assign frame_idx  = FW'(frame_reg);
    assign frame_ok   = (32'(frame_reg) < FRAMES);
    assign clear_word = {3'b000, PAGE_BITS'(idx_reg)};

    // Apply the command to the frame read back
    always_comb
    begin
        mod_word = ram_rdata;
        io_bump  = 1'b0;
        unique case (cmd_reg)
            cbfm_pkg::CMD_PIN:
            begin
                mod_word[PIN_BIT] = 1'b1;
            end
            cbfm_pkg::CMD_UNPIN:
            begin
                mod_word[PIN_BIT] = 1'b0;
            end
            cbfm_pkg::CMD_DIRTY:
            begin
                mod_word[DIRTY_BIT] = 1'b1;
            end
            cbfm_pkg::CMD_WRITE:
            begin
                mod_word[REF_BIT]   = 1'b1;
                mod_word[DIRTY_BIT] = 1'b1;
            end
            cbfm_pkg::CMD_LOADED:
            begin
                mod_word[PAGE_BITS-1:0] = page_reg;
                mod_word[DIRTY_BIT]     = 1'b0;
                io_bump                 = 1'b1;
            end
            cbfm_pkg::CMD_SAVED:
            begin
                mod_word[REF_BIT]   = 1'b0;
                mod_word[DIRTY_BIT] = 1'b0;
                io_bump             = 1'b1;
            end
            cbfm_pkg::CMD_SET_ID:
            begin
                mod_word[PAGE_BITS-1:0] = page_reg;
            end
            default:
            begin
                mod_word = ram_rdata;
            end
        endcase
    end

    // Select the RAM write
    always_comb
    begin
        ram_we    = ctl.clear_wr || ctl.vic_clear_ref || ctl.mod_wr;
        ram_waddr = idx_reg;
        ram_wdata = clear_word;
        if (ctl.mod_wr)
        begin
            ram_waddr = frame_idx;
            ram_wdata = mod_word;
        end
        else if (ctl.vic_clear_ref)
        begin
            ram_wdata          = ram_rdata;
            ram_wdata[REF_BIT] = 1'b0;
        end
    end

    assign ram_raddr = ctl.rd_frame ? frame_idx : idx_reg;

    cbfm_ram #(
        .WIDTH (WW),
        .DEPTH (FRAMES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Advance scan, hand, counters and result
    always_comb
    begin
        idx_next       = idx_reg;
        hand_next      = hand_reg;
        io_next        = io_reg;
        pin_cnt_next   = pin_cnt_reg;
        res_frame_next = res_frame_reg;
        res_found_next = res_found_reg;
        res_none_next  = res_none_reg;
        res_page_next  = res_page_reg;
        res_dirty_next = res_dirty_reg;
        res_pin_next   = res_pin_reg;

        if (ctl.clear_wr || ctl.idx_inc)
        begin
            idx_next = idx_wrap;
        end
        if (ctl.find_start)
        begin
            idx_next = '0;
        end
        if (ctl.vic_start)
        begin
            idx_next = hand_reg;
        end
        if (ctl.accept)
        begin
            res_frame_next = req.frame;
            res_found_next = 1'b0;
            res_none_next  = 1'b0;
        end
        if (ctl.none_free_set)
        begin
            res_none_next = 1'b1;
        end
        if (ctl.find_hit || ctl.vic_take)
        begin
            res_frame_next = 6'(idx_reg);
        end
        if (ctl.find_hit)
        begin
            res_found_next = 1'b1;
        end
        if (ctl.vic_take)
        begin
            hand_next = idx_wrap;
        end
        if (ctl.find_hit || ctl.vic_take || ctl.rep_cap)
        begin
            res_page_next  = ram_rdata[PAGE_BITS-1:0];
            res_dirty_next = ram_rdata[DIRTY_BIT];
            res_pin_next   = ram_rdata[PIN_BIT];
        end
        if (ctl.rep_zero)
        begin
            res_page_next  = '0;
            res_dirty_next = 1'b0;
            res_pin_next   = 1'b0;
        end
        if (ctl.mod_wr)
        begin
            res_page_next  = mod_word[PAGE_BITS-1:0];
            res_dirty_next = mod_word[DIRTY_BIT];
            res_pin_next   = mod_word[PIN_BIT];
            if (io_bump)
            begin
                io_next = io_reg + 32'd1;
            end
            if (mod_word[PIN_BIT] && !ram_rdata[PIN_BIT])
            begin
                pin_cnt_next = pin_cnt_reg + 1'b1;
            end
            else if (!mod_word[PIN_BIT] && ram_rdata[PIN_BIT])
            begin
                pin_cnt_next = pin_cnt_reg - 1'b1;
            end
        end
    end

    // Output register: load a finished result, drop it once taken
    always_comb
    begin
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;
        if (ctl.out_load)
        begin
            rsp_next.frame_out  = res_frame_reg;
            rsp_next.found      = res_found_reg;
            rsp_next.none_free  = res_none_reg;
            rsp_next.page_out   = 16'(res_page_reg);
            rsp_next.dirty_out  = res_dirty_reg;
            rsp_next.pinned_out = res_pin_reg;
            rsp_next.io_total   = io_reg;
            rsp_valid_next      = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            hand_reg      <= '0;
            io_reg        <= '0;
            pin_cnt_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            hand_reg      <= hand_next;
            io_reg        <= io_next;
            pin_cnt_reg   <= pin_cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            cmd_reg   <= req.command;
            frame_reg <= req.frame;
            page_reg  <= PAGE_BITS'(req.page);
        end
        res_frame_reg <= res_frame_next;
        res_found_reg <= res_found_next;
        res_none_reg  <= res_none_next;
        res_page_reg  <= res_page_next;
        res_dirty_reg <= res_dirty_next;
        res_pin_reg   <= res_pin_next;
        rsp_reg       <= rsp_next;
    end

    // Status to controller
    always_comb
    begin
        sts.cmd        = cmd_reg;
        sts.frame_ok   = frame_ok;
        sts.all_pinned = (pin_cnt_reg == PCW'(FRAMES));
        sts.idx_last   = (idx_reg == FW'(FRAMES - 1));
        sts.match      = (ram_rdata[PAGE_BITS-1:0] == page_reg);
        sts.rd_pin     = ram_rdata[PIN_BIT];
        sts.rd_ref     = ram_rdata[REF_BIT];
        sts.out_free   = !rsp_valid_reg || !rsp_stall;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

[rtl/cbfm_chk.sv]
// Port-level checker for the frame manager, bound to the top level.
// Depends on cbfm_pkg and clock_buffer_frame_manager_defines.svh.
`include "clock_buffer_frame_manager_defines.svh"

module cbfm_chk #(
    parameter int FRAMES = 64
) (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input cbfm_pkg::rsp_t rsp
);

    // Hold a stalled response
    `CBFM_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

    // Stall requests while one command is at work
    `CBFM_ASSERT_NXT(a_one_at_a_time, req_valid && !req_stall, req_stall)

    // Never report found and all pinned together
    `CBFM_ASSERT_IMP(a_flags_excl, rsp_valid, !(rsp.found && rsp.none_free))

    // Echoed frame of an all-pinned victim search must itself be pinned
    `CBFM_ASSERT_IMP(a_none_free_pinned,
        rsp_valid && rsp.none_free && (32'(rsp.frame_out) < FRAMES), rsp.pinned_out)

    // Frame beyond the table reports zero fields
    `CBFM_ASSERT_IMP(a_no_frame_zero, rsp_valid && (32'(rsp.frame_out) >= FRAMES),
        (rsp.page_out == 16'd0) && !rsp.dirty_out && !rsp.pinned_out)

endmodule

bind clock_buffer_frame_manager cbfm_chk #(
    .FRAMES (FRAMES)
) u_cbfm_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
